[rtl/udfu_pkg.sv]
`default_nettype none

package udfu_pkg;

  localparam int unsigned BLOCK_SIZE   = 1024;
  localparam int unsigned POLL_TIMEOUT = 20;

  localparam logic [15:0] BLOCK_SIZE_W = 16'(BLOCK_SIZE);

  // reset values of the configuration registers
  localparam logic [31:0] APP_BASE_RST   = 32'h0800_2000;
  localparam logic [31:0] APP_LENGTH_RST = 32'd491520;

  typedef enum logic [3:0] {
    OP_SETIFACE   = 4'd0,
    OP_GETIFACE   = 4'd1,
    OP_OTHERSTD   = 4'd2,
    OP_DETACH     = 4'd3,
    OP_DNLOAD     = 4'd4,
    OP_UPLOAD     = 4'd5,
    OP_GETSTATUS  = 4'd6,
    OP_CLRSTATUS  = 4'd7,
    OP_GETSTATE   = 4'd8,
    OP_ABORT      = 4'd9,
    OP_OTHERCLASS = 4'd10,
    OP_OTHER      = 4'd11
  } dfu_op_e;

  typedef enum logic [3:0] {
    ST_APP_IDLE   = 4'd0,
    ST_APP_DETACH = 4'd1,
    ST_IDLE       = 4'd2,
    ST_DNSYNC     = 4'd3,
    ST_DNBUSY     = 4'd4,
    ST_DNIDLE     = 4'd5,
    ST_MANSYNC    = 4'd6,
    ST_MANIFEST   = 4'd7,
    ST_MANWAIT    = 4'd8,
    ST_UPIDLE     = 4'd9,
    ST_ERROR      = 4'd10
  } dfu_state_e;

  typedef enum logic [3:0] {
    CFG_APP_BASE      = 4'd0,
    CFG_APP_LENGTH    = 4'd1,
    CFG_EEPROM_BASE   = 4'd2,
    CFG_EEPROM_LENGTH = 4'd3,
    CFG_EEPROM_ENABLE = 4'd4,
    CFG_UPLOAD_ENABLE = 4'd5,
    CFG_DETACH_ENABLE = 4'd6,
    CFG_NOSYNC_MODE   = 4'd7
  } cfg_reg_e;

  localparam logic [3:0] STAT_OK      = 4'd0;
  localparam logic [3:0] STAT_ADDRESS = 4'd8;
  localparam logic [3:0] STAT_STALLED = 4'd15;

  typedef struct packed {
    dfu_op_e     op;
    logic [15:0] w_index;
    logic [15:0] w_value;
    logic [15:0] w_length;
    logic [3:0]  write_status;
  } dfu_req_t;

  typedef struct packed {
    logic        respond;
    logic [3:0]  dfu_state;
    logic [3:0]  dfu_status;
    logic        interface_sel;
    logic [31:0] mem_address;
    logic [12:0] block_count;
    logic        do_write;
    logic        do_read;
    logic        detach;
    logic        arm_transfer_timeout;
  } dfu_rsp_t;

endpackage

`default_nettype wire

[rtl/usb_dfu_request_state_machine_core.sv]
`default_nettype none

// DFU 1.1 class request engine. Each decoded control request on the input channel
// is answered by exactly one response on the output channel, carrying the ack/stall
// decision, the reported DFU state and status, the alternate setting and, for
// download and upload, the block address and byte count. Decode and the state update
// sit between the request handshake and the response register, so one request is
// accepted per clock while the response register is empty or being drained. The
// user must write configuration through the cfg channel while no request is in
// flight, which the block does not enforce; region changes take effect at the next return to dfuIDLE.
module usb_dfu_request_state_machine_core
  import udfu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire dfu_req_t    in_req_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output dfu_rsp_t         out_rsp_o
);

  logic [31:0] app_base_q, app_length_q, eeprom_base_q, eeprom_length_q;
  logic        eeprom_en_q, upload_en_q, detach_en_q, nosync_q;

  dfu_state_e  state_q, state_d;
  logic [3:0]  status_q, status_d;
  logic        alt_q, alt_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] left_q, left_d;

  logic        out_valid_q;
  dfu_rsp_t    rsp_q, rsp_d;

  logic        accept;
  logic        bad_req;
  logic        go_idle;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_base_q      <= APP_BASE_RST;
      app_length_q    <= APP_LENGTH_RST;
      eeprom_base_q   <= '0;
      eeprom_length_q <= '0;
      eeprom_en_q     <= 1'b0;
      upload_en_q     <= 1'b0;
      detach_en_q     <= 1'b0;
      nosync_q        <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_APP_BASE:      app_base_q      <= cfg_data_i;
        CFG_APP_LENGTH:    app_length_q    <= cfg_data_i;
        CFG_EEPROM_BASE:   eeprom_base_q   <= cfg_data_i;
        CFG_EEPROM_LENGTH: eeprom_length_q <= cfg_data_i;
        CFG_EEPROM_ENABLE: eeprom_en_q     <= cfg_data_i[0];
        CFG_UPLOAD_ENABLE: upload_en_q     <= cfg_data_i[0];
        CFG_DETACH_ENABLE: detach_en_q     <= cfg_data_i[0];
        CFG_NOSYNC_MODE:   nosync_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  logic        set_ok;
  logic        oversize;
  logic        dn_state_ok;
  logic        dn_past_end;
  logic        up_ok;
  logic [15:0] up_cnt;
  logic [31:0] len_ext;

  assign accept   = in_valid_i && in_ready_o;
  assign len_ext  = {16'b0, in_req_i.w_length};
  assign set_ok   = (in_req_i.w_index == 16'd0) &&
                    ((in_req_i.w_value == 16'd0) ||
                     ((in_req_i.w_value == 16'd1) && eeprom_en_q));
  assign oversize = in_req_i.w_length > BLOCK_SIZE_W;
  assign dn_state_ok = (state_q == ST_IDLE) || (state_q == ST_DNSYNC) ||
                       (state_q == ST_DNIDLE);
  assign dn_past_end = len_ext > left_q;
  assign up_ok    = upload_en_q && !oversize &&
                    ((state_q == ST_IDLE) || (state_q == ST_UPIDLE));
  // when bytes_left is not the larger it is at most w_length, so 16 bits hold it
  assign up_cnt   = (len_ext < left_q) ? in_req_i.w_length : left_q[15:0];

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    alt_d    = alt_q;
    addr_d   = addr_q;
    left_d   = left_q;
    bad_req  = 1'b0;
    go_idle  = 1'b0;

    unique case (in_req_i.op)
      OP_SETIFACE: begin
        if (set_ok) begin
          alt_d   = in_req_i.w_value[0];
          go_idle = 1'b1;
        end
      end
      OP_DETACH: bad_req = !detach_en_q;
      OP_DNLOAD: begin
        if (oversize || !dn_state_ok) begin
          bad_req = 1'b1;
        end else if (in_req_i.w_length == 16'd0) begin
          state_d = ST_MANSYNC;
        end else if (dn_past_end) begin
          status_d = STAT_ADDRESS;
          state_d  = ST_ERROR;
        end else begin
          status_d = in_req_i.write_status;
          if (in_req_i.write_status == STAT_OK) begin
            addr_d  = addr_q + len_ext;
            left_d  = left_q - len_ext;
            state_d = nosync_q ? ST_DNIDLE : ST_DNSYNC;
          end else begin
            state_d = ST_ERROR;
          end
        end
      end
      OP_UPLOAD: begin
        if (!up_ok) begin
          bad_req = 1'b1;
        end else if (left_q == 32'd0) begin
          go_idle = 1'b1;
        end else if (up_cnt != 16'd0) begin
          addr_d  = addr_q + {16'b0, up_cnt};
          left_d  = left_q - {16'b0, up_cnt};
          state_d = ST_UPIDLE;
        end
      end
      OP_GETSTATUS: begin
        unique case (state_q)
          ST_IDLE, ST_DNIDLE, ST_UPIDLE, ST_ERROR: ;
          ST_DNSYNC:  state_d = ST_DNIDLE;
          ST_MANSYNC: go_idle = 1'b1;
          default:    bad_req = 1'b1;
        endcase
      end
      OP_CLRSTATUS: begin
        if (state_q == ST_ERROR) go_idle = 1'b1;
        else bad_req = 1'b1;
      end
      OP_ABORT: begin
        unique case (state_q)
          ST_IDLE, ST_DNSYNC, ST_DNIDLE, ST_MANSYNC, ST_UPIDLE: go_idle = 1'b1;
          default: bad_req = 1'b1;
        endcase
      end
      OP_OTHERCLASS: bad_req = 1'b1;
      default: ;
    endcase

    if (bad_req) begin
      state_d  = ST_ERROR;
      status_d = STAT_STALLED;
    end
    if (go_idle) begin
      state_d  = ST_IDLE;
      status_d = STAT_OK;
      if (alt_d && eeprom_en_q) begin
        addr_d = eeprom_base_q;
        left_d = eeprom_length_q;
      end else begin
        addr_d = app_base_q;
        left_d = app_length_q;
      end
    end
  end

  // ---------------------------------------------------------------- response
  always_comb begin
    rsp_d = '0;
    rsp_d.interface_sel = alt_d;
    // get status reports what the host saw before the request
    if (in_req_i.op == OP_GETSTATUS) begin
      rsp_d.dfu_state  = state_q;
      rsp_d.dfu_status = status_q;
    end else begin
      rsp_d.dfu_state  = state_d;
      rsp_d.dfu_status = status_d;
    end

    unique case (in_req_i.op)
      OP_SETIFACE: rsp_d.respond = !set_ok;
      OP_DETACH: begin
        rsp_d.respond = bad_req;
        rsp_d.detach  = detach_en_q;
      end
      OP_DNLOAD: begin
        rsp_d.respond              = bad_req;
        rsp_d.arm_transfer_timeout = !bad_req;
        if (!bad_req && (in_req_i.w_length != 16'd0) && !dn_past_end) begin
          rsp_d.do_write    = 1'b1;
          rsp_d.mem_address = addr_q;
          rsp_d.block_count = in_req_i.w_length[12:0];
        end
      end
      OP_UPLOAD: begin
        rsp_d.respond              = bad_req;
        rsp_d.arm_transfer_timeout = !bad_req;
        if (!bad_req && (left_q != 32'd0) && (up_cnt != 16'd0)) begin
          rsp_d.do_read     = 1'b1;
          rsp_d.mem_address = addr_q;
          rsp_d.block_count = up_cnt[12:0];
        end
      end
      OP_GETIFACE, OP_GETSTATE: rsp_d.respond = 1'b0;
      OP_GETSTATUS, OP_CLRSTATUS, OP_ABORT, OP_OTHERCLASS: rsp_d.respond = bad_req;
      default: rsp_d.respond = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      status_q <= STAT_OK;
      alt_q    <= 1'b0;
      addr_q   <= APP_BASE_RST;
      left_q   <= APP_LENGTH_RST;
    end else if (accept) begin
      state_q  <= state_d;
      status_q <= status_d;
      alt_q    <= alt_d;
      addr_q   <= addr_d;
      left_q   <= left_d;
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // ---------------------------------------------------------------- checks
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no response");

  a_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERROR) == (status_q != STAT_OK))
    else $error("error state and status disagree");

  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.do_write && out_rsp_o.do_read))
    else $error("read and write in one response");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.block_count <= 13'(BLOCK_SIZE)))
    else $error("block count above block size");

endmodule

`default_nettype wire

[test/usb_dfu_request_state_machine_core_tb.sv]
`timescale 1ns / 100ps

module usb_dfu_request_state_machine_core_tb;
  import udfu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 29;
  localparam int unsigned PHASE_ITEMS = 275;
  localparam int unsigned NUM_PHASES  = 6;
  localparam logic [3:0]  CFG_UNUSED  = 4'd15;
  localparam logic [3:0]  OP_RESERVED = 4'd15;

  // Tracks DFU state, status and transfer region; holds the responses still owed
  class dfu_response_tracker;
    logic [31:0] app_base, app_length, eeprom_base, eeprom_length;
    bit          eeprom_en, upload_en, detach_en, nosync;
    dfu_state_e  state;
    logic [3:0]  status;
    bit          alt;
    logic [31:0] next_addr, bytes_left;
    dfu_rsp_t    owed_rsp_q[$];
    int unsigned errors;

    function new();
      app_base      = APP_BASE_RST;
      app_length    = APP_LENGTH_RST;
      eeprom_base   = '0;
      eeprom_length = '0;
      eeprom_en     = 1'b0;
      upload_en     = 1'b0;
      detach_en     = 1'b0;
      nosync        = 1'b0;
      alt           = 1'b0;
      errors        = 0;
      go_idle();
    endfunction

    function void go_idle();
      state  = ST_IDLE;
      status = STAT_OK;
      if (alt && eeprom_en) begin
        next_addr  = eeprom_base;
        bytes_left = eeprom_length;
      end else begin
        next_addr  = app_base;
        bytes_left = app_length;
      end
    endfunction

    function bit stall();
      state  = ST_ERROR;
      status = STAT_STALLED;
      return 1'b1;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] d);
      case (idx)
        CFG_APP_BASE:      app_base = d;
        CFG_APP_LENGTH:    app_length = d;
        CFG_EEPROM_BASE:   eeprom_base = d;
        CFG_EEPROM_LENGTH: eeprom_length = d;
        CFG_EEPROM_ENABLE: eeprom_en = d[0];
        CFG_UPLOAD_ENABLE: upload_en = d[0];
        CFG_DETACH_ENABLE: detach_en = d[0];
        CFG_NOSYNC_MODE:   nosync = d[0];
        default: ;
      endcase
    endfunction

    function void note_request(dfu_req_t r);
      dfu_rsp_t    e;
      dfu_state_e  st_prior;
      logic [3:0]  stat_prior;
      bit          report_prior;
      logic [31:0] n;
      e            = '0;
      st_prior     = state;
      stat_prior   = status;
      report_prior = 1'b0;
      case (r.op)
        OP_SETIFACE: begin
          if (r.w_index != 16'd0 || r.w_value > 16'd1 || (r.w_value == 16'd1 && !eeprom_en)) begin
            e.respond = 1'b1;
          end else begin
            alt = r.w_value[0];
            go_idle();
          end
        end
        OP_GETIFACE, OP_GETSTATE: ;
        OP_DETACH: begin
          if (detach_en) e.detach = 1'b1;
          else e.respond = stall();
        end
        OP_DNLOAD: begin
          if (r.w_length > BLOCK_SIZE_W ||
              (state != ST_IDLE && state != ST_DNSYNC && state != ST_DNIDLE)) begin
            e.respond = stall();
          end else begin
            e.arm_transfer_timeout = 1'b1;
            if (r.w_length == 16'd0) begin
              state = ST_MANSYNC;
            end else if (32'(r.w_length) > bytes_left) begin
              status = STAT_ADDRESS;
              state  = ST_ERROR;
            end else begin
              e.do_write    = 1'b1;
              e.mem_address = next_addr;
              e.block_count = 13'(r.w_length);
              status        = r.write_status;
              if (r.write_status == STAT_OK) begin
                next_addr  = next_addr + 32'(r.w_length);
                bytes_left = bytes_left - 32'(r.w_length);
                state      = nosync ? ST_DNIDLE : ST_DNSYNC;
              end else begin
                state = ST_ERROR;
              end
            end
          end
        end
        OP_UPLOAD: begin
          if (!upload_en || r.w_length > BLOCK_SIZE_W ||
              (state != ST_IDLE && state != ST_UPIDLE)) begin
            e.respond = stall();
          end else begin
            e.arm_transfer_timeout = 1'b1;
            if (bytes_left == 32'd0) begin
              go_idle();
            end else begin
              n = (32'(r.w_length) < bytes_left) ? 32'(r.w_length) : bytes_left;
              e.block_count = n[12:0];
              // zero wLength with bytes remaining leaves everything as it was
              if (n != 32'd0) begin
                e.do_read     = 1'b1;
                e.mem_address = next_addr;
                next_addr     = next_addr + n;
                bytes_left    = bytes_left - n;
                state         = ST_UPIDLE;
              end
            end
          end
        end
        OP_GETSTATUS: begin
          report_prior = 1'b1;
          case (state)
            ST_IDLE, ST_DNIDLE, ST_UPIDLE, ST_ERROR: ;
            ST_DNSYNC:  state = ST_DNIDLE;
            ST_MANSYNC: go_idle();
            default:    e.respond = stall();
          endcase
        end
        OP_CLRSTATUS: begin
          if (state == ST_ERROR) go_idle();
          else e.respond = stall();
        end
        OP_ABORT: begin
          case (state)
            ST_IDLE, ST_DNSYNC, ST_DNIDLE, ST_MANSYNC, ST_UPIDLE: go_idle();
            default: e.respond = stall();
          endcase
        end
        OP_OTHERCLASS: e.respond = stall();
        default: e.respond = 1'b1;
      endcase
      e.dfu_state     = report_prior ? st_prior : state;
      e.dfu_status    = report_prior ? stat_prior : status;
      e.interface_sel = alt;
      owed_rsp_q.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_response(dfu_rsp_t got);
      dfu_rsp_t w;
      if (owed_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: response with no request outstanding, expected none actual %h",
                 $time, got);
        return;
      end
      w = owed_rsp_q.pop_front();
      cmp("respond", w.respond, got.respond);
      cmp("dfu_state", w.dfu_state, got.dfu_state);
      cmp("dfu_status", w.dfu_status, got.dfu_status);
      cmp("interface_sel", w.interface_sel, got.interface_sel);
      cmp("mem_address", w.mem_address, got.mem_address);
      cmp("block_count", w.block_count, got.block_count);
      cmp("do_write", w.do_write, got.do_write);
      cmp("do_read", w.do_read, got.do_read);
      cmp("detach", w.detach, got.detach);
      cmp("arm_transfer_timeout", w.arm_transfer_timeout, got.arm_transfer_timeout);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  dfu_req_t    in_req_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  dfu_rsp_t    out_rsp_o;

  dfu_response_tracker track;
  logic [31:0] cfg_set [8];
  bit          quiet  = 1'b0;
  int unsigned sent   = 0;
  int unsigned cycles = 0;

  usb_dfu_request_state_machine_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_valid_o && out_ready_i) track.check_response(out_rsp_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic dfu_req_t req(dfu_op_e op, int unsigned idx, int unsigned val,
                                   int unsigned len, int unsigned ws);
    dfu_req_t r;
    r.op           = op;
    r.w_index      = idx[15:0];
    r.w_value      = val[15:0];
    r.w_length     = len[15:0];
    r.write_status = ws[3:0];
    return r;
  endfunction

  // valid is left high after acceptance; the next request or a drain decides
  task automatic send_req(input dfu_req_t r);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    track.note_request(r);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (track.owed_rsp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_regs(input bit poke_unused);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 4'(i);
      cfg_data_i  <= cfg_set[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      track.write_reg(4'(i), cfg_set[i]);
    end
    if (poke_unused) begin
      cfg_index_i <= CFG_UNUSED;
      cfg_data_i  <= $urandom;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int unsigned dn_len();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom_range(BLOCK_SIZE + 1, 65535);
    if (pick == 1) return BLOCK_SIZE;
    if (pick == 2) return 1;
    return $urandom_range(1, BLOCK_SIZE);
  endfunction

  function automatic int unsigned up_len();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(BLOCK_SIZE + 1, 65535);
    return $urandom_range(1, BLOCK_SIZE);
  endfunction

  task automatic recover();
    if (track.state == ST_ERROR) send_req(req(OP_CLRSTATUS, 0, 0, 0, $urandom));
    else if (track.state != ST_IDLE) send_req(req(OP_ABORT, 0, 0, 0, $urandom));
  endtask

  task automatic download_run();
    int unsigned blocks;
    blocks = $urandom_range(1, 6);
    recover();
    if ($urandom_range(0, 3) == 0) send_req(req(OP_SETIFACE, 0, $urandom_range(0, 1), 0, 0));
    repeat (blocks) begin
      send_req(req(OP_DNLOAD, $urandom, $urandom, dn_len(),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : STAT_OK));
      if (!track.nosync && $urandom_range(0, 4) != 0)
        send_req(req(OP_GETSTATUS, $urandom, $urandom, $urandom, $urandom));
    end
    // end of image: manifest sync, then back to idle
    send_req(req(OP_DNLOAD, $urandom, $urandom, 0, $urandom));
    send_req(req(OP_GETSTATUS, 0, 0, 6, 0));
    send_req(req(OP_GETSTATUS, 0, 0, 6, 0));
  endtask

  task automatic upload_run();
    int unsigned blocks;
    blocks = $urandom_range(1, 6);
    recover();
    if ($urandom_range(0, 3) == 0) send_req(req(OP_SETIFACE, 0, $urandom_range(0, 1), 0, 0));
    repeat (blocks) send_req(req(OP_UPLOAD, $urandom, $urandom, up_len(), $urandom));
    if ($urandom_range(0, 9) < 7) send_req(req(OP_ABORT, $urandom, $urandom, 0, $urandom));
  endtask

  task automatic random_round();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      download_run();
    end else if (pick < 13) begin
      upload_run();
    end else if (pick < 15) begin
      send_req(req(OP_SETIFACE, ($urandom_range(0, 5) == 0) ? $urandom : 0,
                   ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1), $urandom, 0));
    end else if (pick == 15) begin
      send_req(req(OP_DETACH, $urandom, $urandom, $urandom, $urandom));
    end else begin
      send_req(req(dfu_op_e'($urandom_range(0, 15)), $urandom, $urandom, $urandom, $urandom));
      if ($urandom_range(0, 1) == 0) send_req(req(OP_CLRSTATUS, 0, 0, 0, 0));
    end
  endtask

  initial begin
    int unsigned goal;
    track = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: upload, detach and the EEPROM region all disabled
    send_req(req(OP_UPLOAD, 0, 0, 16, 0));
    send_req(req(OP_GETSTATUS, 0, 0, 6, 0));
    send_req(req(OP_DETACH, 0, 0, 0, 0));
    send_req(req(OP_CLRSTATUS, 0, 0, 0, 0));
    send_req(req(OP_SETIFACE, 0, 1, 0, 0));
    drain();

    // region wraps past the top of the address space
    cfg_set = '{32'hFFFF_FFF0, 32'd1030, 32'h0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd0};
    write_regs(1'b0);
    send_req(req(OP_SETIFACE, 0, 0, 0, 0));
    send_req(req(OP_DNLOAD, 0, 0, BLOCK_SIZE, STAT_OK));
    send_req(req(OP_GETSTATUS, 0, 0, 6, 0));
    send_req(req(OP_DNLOAD, 0, 0, BLOCK_SIZE + 1, STAT_OK));
    send_req(req(OP_ABORT, 0, 0, 0, 0));
    send_req(req(OP_CLRSTATUS, 0, 0, 0, 0));
    send_req(req(OP_DNLOAD, 0, 0, BLOCK_SIZE, STAT_OK));
    send_req(req(OP_DNLOAD, 0, 0, 7, STAT_OK));
    send_req(req(OP_CLRSTATUS, 0, 0, 0, 0));
    send_req(req(OP_DNLOAD, 0, 0, 4, 4'hF));
    send_req(req(OP_CLRSTATUS, 0, 0, 0, 0));
    send_req(req(OP_DNLOAD, 0, 0, 0, 0));
    send_req(req(OP_GETSTATUS, 0, 0, 6, 0));
    send_req(req(OP_UPLOAD, 0, 0, 0, 0));
    send_req(req(OP_UPLOAD, 0, 0, BLOCK_SIZE, 0));
    send_req(req(OP_UPLOAD, 0, 0, BLOCK_SIZE, 0));
    send_req(req(OP_UPLOAD, 0, 0, BLOCK_SIZE, 0));
    send_req(req(OP_SETIFACE, 16'hFFFF, 0, 0, 0));
    send_req(req(OP_SETIFACE, 0, 16'hFFFF, 0, 0));
    send_req(req(OP_SETIFACE, 0, 1, 0, 0));
    send_req(req(OP_DETACH, 0, 0, 0, 0));
    send_req(req(OP_GETIFACE, 0, 0, 1, 0));
    send_req(req(OP_OTHERSTD, 0, 0, 0, 0));
    send_req(req(OP_OTHER, 0, 0, 0, 0));
    send_req(req(dfu_op_e'(OP_RESERVED), 0, 0, 0, 0));
    send_req(req(OP_OTHERCLASS, 0, 0, 0, 0));
    send_req(req(OP_GETSTATE, 0, 0, 1, 0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: cfg_set = '{$urandom, $urandom_range(0, 6000), $urandom, $urandom_range(0, 6000),
                       32'd1, 32'd1, 32'd1, 32'd0};
        1: cfg_set = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        2: cfg_set = '{$urandom, $urandom_range(0, 20000), $urandom, $urandom_range(0, 20000),
                       $urandom, $urandom, $urandom, $urandom};
        3: cfg_set = '{32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                       32'hFFFF_FFFE, 32'hFFFF_FFFE};
        4: cfg_set = '{$urandom, $urandom_range(0, 4000), $urandom, $urandom_range(0, 4000),
                       32'd1, 32'd1, $urandom, 32'd1};
        default: cfg_set = '{$urandom, $urandom_range(0, 3000), $urandom,
                             $urandom_range(0, 3000), $urandom, 32'd1, $urandom, $urandom};
      endcase
      quiet = (p == 2);
      write_regs(p == NUM_PHASES - 1);
      goal = sent + PHASE_ITEMS;
      while (sent < goal) random_round();
    end

    drain();
    if (track.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[usb_dfu_request_state_machine_core.f]
rtl/udfu_pkg.sv
rtl/usb_dfu_request_state_machine_core.sv
test/usb_dfu_request_state_machine_core_tb.sv
